>>> rtl/cursor_list_parity_split_defines.svh
// Assertion macros for the cursor list block checker.
`ifndef CURSOR_LIST_PARITY_SPLIT_DEFINES_SVH
`define CURSOR_LIST_PARITY_SPLIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define CLPS_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define CLPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/clps_pkg.sv
// Package: types, constants, microcode table and helpers for the cursor list block.
`timescale 1ns / 1ps

package clps_pkg;

    localparam int POOL_NODES = 16;
    localparam int IDX_W      = $clog2(POOL_NODES);
    localparam int LINK_W     = (POOL_NODES > 31) ? 16 : 5;
    localparam int CNT_W      = $clog2(POOL_NODES + 1);
    localparam int VAL_W      = 32;
    localparam int STEP_W     = 4;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [LINK_W-1:0] link_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [STEP_W-1:0] step_t;

    localparam link_t NIL_LINK = '1;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_SPLIT  = 2'd1;
    localparam logic [1:0] CMD_DUMP   = 2'd2;

    typedef struct packed {
        logic [1:0]              command;
        logic signed [VAL_W-1:0] value;
    } item_t;

    typedef struct packed {
        logic                    status;
        logic                    list_id;
        logic signed [VAL_W-1:0] element;
        logic                    element_valid;
        logic                    last;
    } result_t;

    typedef enum logic [3:0] {
        A_NONE,
        A_INS_CHECK,
        A_INS_LINK,
        A_SPLIT_INIT,
        A_READ_CUR,
        A_SPLIT_TEST,
        A_SPLIT_UNLINK,
        A_EMIT_DONE,
        A_DUMP_INIT,
        A_DUMP_TAKE,
        A_DUMP_PASS,
        A_DUMP_FIN,
        A_EMIT_FULL
    } act_t;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_FREE_EMPTY,
        C_WALK_END,
        C_ODD,
        C_PASS1
    } cond_t;

    typedef struct packed {
        act_t  act;
        cond_t cond;
        step_t target;
        logic  fin;
    } ucode_t;

    typedef struct packed {
        logic load;
        act_t act;
    } dp_ctrl_t;

    typedef struct packed {
        logic free_empty;
        logic walk_end;
        logic odd;
        logic pass1;
    } dp_flags_t;

    localparam step_t ST_INS_CHECK   = 4'd0;
    localparam step_t ST_INS_LINK    = 4'd1;
    localparam step_t ST_SPLIT_INIT  = 4'd2;
    localparam step_t ST_SPLIT_READ  = 4'd3;
    localparam step_t ST_SPLIT_TEST  = 4'd4;
    localparam step_t ST_SPLIT_UNLNK = 4'd5;
    localparam step_t ST_DONE        = 4'd6;
    localparam step_t ST_DUMP_INIT   = 4'd7;
    localparam step_t ST_DUMP_READ   = 4'd8;
    localparam step_t ST_DUMP_TAKE   = 4'd9;
    localparam step_t ST_DUMP_PEND   = 4'd10;
    localparam step_t ST_DUMP_PASS   = 4'd11;
    localparam step_t ST_DUMP_FIN    = 4'd12;
    localparam step_t ST_FULL        = 4'd13;

    function automatic ucode_t ucode(input step_t pc);
        ucode_t w;
        w = '{act: A_NONE, cond: C_NEVER, target: ST_DONE, fin: 1'b1};
        case (pc)
            ST_INS_CHECK:   w = '{A_INS_CHECK,    C_FREE_EMPTY, ST_FULL,       1'b0};
            ST_INS_LINK:    w = '{A_INS_LINK,     C_NEVER,      ST_DONE,       1'b1};
            ST_SPLIT_INIT:  w = '{A_SPLIT_INIT,   C_NEVER,      ST_DONE,       1'b0};
            ST_SPLIT_READ:  w = '{A_READ_CUR,     C_WALK_END,   ST_DONE,       1'b0};
            ST_SPLIT_TEST:  w = '{A_SPLIT_TEST,   C_ODD,        ST_SPLIT_READ, 1'b0};
            ST_SPLIT_UNLNK: w = '{A_SPLIT_UNLINK, C_ALWAYS,     ST_SPLIT_READ, 1'b0};
            ST_DONE:        w = '{A_EMIT_DONE,    C_NEVER,      ST_DONE,       1'b1};
            ST_DUMP_INIT:   w = '{A_DUMP_INIT,    C_NEVER,      ST_DONE,       1'b0};
            ST_DUMP_READ:   w = '{A_READ_CUR,     C_WALK_END,   ST_DUMP_PEND,  1'b0};
            ST_DUMP_TAKE:   w = '{A_DUMP_TAKE,    C_ALWAYS,     ST_DUMP_READ,  1'b0};
            ST_DUMP_PEND:   w = '{A_NONE,         C_PASS1,      ST_DUMP_FIN,   1'b0};
            ST_DUMP_PASS:   w = '{A_DUMP_PASS,    C_ALWAYS,     ST_DUMP_READ,  1'b0};
            ST_DUMP_FIN:    w = '{A_DUMP_FIN,     C_NEVER,      ST_DONE,       1'b1};
            ST_FULL:        w = '{A_EMIT_FULL,    C_NEVER,      ST_DONE,       1'b1};
            default:        w = '{A_EMIT_DONE,    C_NEVER,      ST_DONE,       1'b1};
        endcase
        return w;
    endfunction

    function automatic step_t entry_step(input logic [1:0] command);
        step_t s;
        case (command)
            CMD_INSERT: s = ST_INS_CHECK;
            CMD_SPLIT:  s = ST_SPLIT_INIT;
            CMD_DUMP:   s = ST_DUMP_INIT;
            default:    s = ST_DONE;
        endcase
        return s;
    endfunction

    function automatic logic is_node(input link_t link);
        return link < link_t'(POOL_NODES);
    endfunction

    function automatic link_t reset_link(input idx_t idx);
        return (idx == '0) ? NIL_LINK : (link_t'(idx) - link_t'(1));
    endfunction

endpackage

>>> rtl/cursor_list_parity_split.sv
// Top level: pooled linked lists with free chain, even split and dump.
//
//   channel  | handshake           | word
//   ---------+---------------------+----------------------------------------
//   command  | start, busy         | item   (command, value)
//   result   | strobe (one cycle)  | result (status, list_id, element,
//            |                     |         element_valid, last)
//
// One microcode step per clock, one link/value memory read per step.
// Insert links a free node, else reports full; split moves even nodes out.
// Dump walks the main, then the even list (at most POOL_NODES). Others end.
// Results are registered and appear in the cycle after their step; no stall.
// Reset restores the free chain at once through link valid bits.
`timescale 1ns / 1ps

module cursor_list_parity_split
    import clps_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  item_t   item,
    output logic    strobe,
    output result_t result
);

    logic             accept;
    dp_ctrl_t         ctrl;
    dp_flags_t        flags;
    idx_t             rd_addr;
    logic [VAL_W-1:0] val_rdata;
    link_t            link_rdata;
    logic             val_we;
    idx_t             val_wr_addr;
    logic [VAL_W-1:0] val_wr_data;
    logic             link_we;
    idx_t             link_wr_addr;
    link_t            link_wr_data;

    assign accept = start && !busy;

    clps_useq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .command (item.command),
        .flags   (flags),
        .ctrl    (ctrl),
        .busy    (busy)
    );

    clps_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .item         (item),
        .flags        (flags),
        .rd_addr      (rd_addr),
        .val_rdata    (val_rdata),
        .link_rdata   (link_rdata),
        .val_we       (val_we),
        .val_wr_addr  (val_wr_addr),
        .val_wr_data  (val_wr_data),
        .link_we      (link_we),
        .link_wr_addr (link_wr_addr),
        .link_wr_data (link_wr_data),
        .result       (result),
        .strobe       (strobe)
    );

    clps_ram #(
        .WIDTH (VAL_W),
        .DEPTH (POOL_NODES)
    ) u_val_ram (
        .clk     (clk),
        .we      (val_we),
        .wr_addr (val_wr_addr),
        .wr_data (val_wr_data),
        .rd_addr (rd_addr),
        .rd_data (val_rdata)
    );

    clps_link_mem u_link (
        .clk     (clk),
        .rst_n   (rst_n),
        .we      (link_we),
        .wr_addr (link_wr_addr),
        .wr_data (link_wr_data),
        .rd_addr (rd_addr),
        .rd_data (link_rdata)
    );

endmodule

>>> rtl/clps_ram.sv
// Generic single-port-write RAM with registered read.
`timescale 1ns / 1ps

module clps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> rtl/clps_link_mem.sv
// Link store: next-index RAM with per-entry valid bits giving the reset chain.
`timescale 1ns / 1ps

module clps_link_mem
    import clps_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  we,
    input  idx_t  wr_addr,
    input  link_t wr_data,
    input  idx_t  rd_addr,
    output link_t rd_data
);

    logic [POOL_NODES-1:0] valid_reg;
    logic [POOL_NODES-1:0] valid_next;
    logic                  rd_valid_reg;
    idx_t                  rd_addr_reg;
    link_t                 ram_q;

    clps_ram #(
        .WIDTH (LINK_W),
        .DEPTH (POOL_NODES)
    ) u_ram (
        .clk     (clk),
        .we      (we),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (ram_q)
    );

    always_comb
    begin
        valid_next = valid_reg;
        if (we)
        begin
            valid_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg    <= valid_next;
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        rd_addr_reg <= rd_addr;
    end

    // unwritten entries read as the reset chain
    assign rd_data = rd_valid_reg ? ram_q : reset_link(rd_addr_reg);

endmodule

>>> rtl/clps_useq.sv
// Microcode sequencer: step counter, control ROM and conditional jumps.
`timescale 1ns / 1ps

module clps_useq
    import clps_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      accept,
    input  logic [1:0] command,
    input  dp_flags_t flags,
    output dp_ctrl_t  ctrl,
    output logic      busy
);

    typedef enum logic [1:0] {
        SEQ_IDLE = 2'b01,
        SEQ_RUN  = 2'b10
    } seq_state_t;

    seq_state_t state_reg, state_next;
    step_t      pc_reg, pc_next;
    ucode_t     cw;
    logic       jump;

    assign cw = ucode(pc_reg);

    always_comb
    begin
        case (cw.cond)
            C_NEVER:      jump = 1'b0;
            C_ALWAYS:     jump = 1'b1;
            C_FREE_EMPTY: jump = flags.free_empty;
            C_WALK_END:   jump = flags.walk_end;
            C_ODD:        jump = flags.odd;
            C_PASS1:      jump = flags.pass1;
            default:      jump = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        case (state_reg)
            SEQ_IDLE:
            begin
                if (accept)
                begin
                    state_next = SEQ_RUN;
                    pc_next    = entry_step(command);
                end
            end
            SEQ_RUN:
            begin
                if (jump)
                begin
                    pc_next = cw.target;
                end
                else if (cw.fin)
                begin
                    state_next = SEQ_IDLE;
                end
                else
                begin
                    pc_next = pc_reg + step_t'(1);
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEQ_IDLE;
            pc_reg    <= ST_DONE;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
        end
    end

    assign busy      = (state_reg == SEQ_RUN);
    assign ctrl.load = accept;
    assign ctrl.act  = busy ? cw.act : A_NONE;

endmodule

>>> rtl/clps_datapath.sv
// Datapath: list heads, walk cursor, pending dump word and result register.
`timescale 1ns / 1ps

module clps_datapath
    import clps_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  dp_ctrl_t         ctrl,
    input  item_t            item,
    output dp_flags_t        flags,
    output idx_t             rd_addr,
    input  logic [VAL_W-1:0] val_rdata,
    input  link_t            link_rdata,
    output logic             val_we,
    output idx_t             val_wr_addr,
    output logic [VAL_W-1:0] val_wr_data,
    output logic             link_we,
    output idx_t             link_wr_addr,
    output link_t            link_wr_data,
    output result_t          result,
    output logic             strobe
);

    link_t            free_head_reg, free_head_next;
    link_t            main_head_reg, main_head_next;
    link_t            even_head_reg, even_head_next;
    link_t            cur_reg, cur_next;
    link_t            prev_reg, prev_next;
    link_t            nxt_reg, nxt_next;
    cnt_t             cnt_reg, cnt_next;
    logic             pass_reg, pass_next;
    logic [VAL_W-1:0] value_reg, value_next;
    logic             pend_v_reg, pend_v_next;
    logic             pend_id_reg, pend_id_next;
    logic [VAL_W-1:0] pend_val_reg, pend_val_next;
    result_t          result_reg, result_next;
    logic             strobe_reg, strobe_next;

    assign flags.free_empty = !is_node(free_head_reg);
    assign flags.walk_end   = (cnt_reg == cnt_t'(POOL_NODES)) || !is_node(cur_reg);
    assign flags.odd        = val_rdata[0];
    assign flags.pass1      = pass_reg;

    assign rd_addr = (ctrl.act == A_INS_CHECK) ? free_head_reg[IDX_W-1:0]
                                               : cur_reg[IDX_W-1:0];

    always_comb
    begin
        free_head_next = free_head_reg;
        main_head_next = main_head_reg;
        even_head_next = even_head_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        nxt_next       = nxt_reg;
        cnt_next       = cnt_reg;
        pass_next      = pass_reg;
        value_next     = value_reg;
        pend_v_next    = pend_v_reg;
        pend_id_next   = pend_id_reg;
        pend_val_next  = pend_val_reg;
        result_next    = result_reg;
        strobe_next    = 1'b0;
        val_we         = 1'b0;
        val_wr_addr    = free_head_reg[IDX_W-1:0];
        val_wr_data    = value_reg;
        link_we        = 1'b0;
        link_wr_addr   = cur_reg[IDX_W-1:0];
        link_wr_data   = even_head_reg;

        if (ctrl.load)
        begin
            value_next = item.value;
        end

        case (ctrl.act)
            A_INS_LINK:
            begin
                val_we         = 1'b1;
                link_we        = 1'b1;
                link_wr_addr   = free_head_reg[IDX_W-1:0];
                link_wr_data   = main_head_reg;
                free_head_next = link_rdata;
                main_head_next = free_head_reg;
                strobe_next    = 1'b1;
                result_next    = '{1'b0, 1'b0, '0, 1'b0, 1'b1};
            end
            A_SPLIT_INIT:
            begin
                prev_next = NIL_LINK;
                cur_next  = main_head_reg;
                cnt_next  = '0;
            end
            A_SPLIT_TEST:
            begin
                if (val_rdata[0])
                begin
                    prev_next = cur_reg;
                    cur_next  = link_rdata;
                    cnt_next  = cnt_reg + cnt_t'(1);
                end
                else
                begin
                    // push onto the even list
                    link_we        = 1'b1;
                    even_head_next = cur_reg;
                    nxt_next       = link_rdata;
                end
            end
            A_SPLIT_UNLINK:
            begin
                if (is_node(prev_reg))
                begin
                    link_we      = 1'b1;
                    link_wr_addr = prev_reg[IDX_W-1:0];
                    link_wr_data = nxt_reg;
                end
                else
                begin
                    main_head_next = nxt_reg;
                end
                cur_next = nxt_reg;
                cnt_next = cnt_reg + cnt_t'(1);
            end
            A_EMIT_DONE:
            begin
                strobe_next = 1'b1;
                result_next = '{1'b0, 1'b0, '0, 1'b0, 1'b1};
            end
            A_EMIT_FULL:
            begin
                strobe_next = 1'b1;
                result_next = '{1'b1, 1'b0, '0, 1'b0, 1'b1};
            end
            A_DUMP_INIT:
            begin
                pass_next   = 1'b0;
                cur_next    = main_head_reg;
                cnt_next    = '0;
                pend_v_next = 1'b0;
            end
            A_DUMP_TAKE:
            begin
                // hold one word back so the final one can carry last
                if (pend_v_reg)
                begin
                    strobe_next = 1'b1;
                    result_next = '{1'b0, pend_id_reg, pend_val_reg, 1'b1, 1'b0};
                end
                pend_v_next   = 1'b1;
                pend_id_next  = pass_reg;
                pend_val_next = val_rdata;
                cur_next      = link_rdata;
                cnt_next      = cnt_reg + cnt_t'(1);
            end
            A_DUMP_PASS:
            begin
                pass_next = 1'b1;
                cur_next  = even_head_reg;
            end
            A_DUMP_FIN:
            begin
                strobe_next = 1'b1;
                if (pend_v_reg)
                begin
                    result_next = '{1'b0, pend_id_reg, pend_val_reg, 1'b1, 1'b1};
                end
                else
                begin
                    result_next = '{1'b0, 1'b0, '0, 1'b0, 1'b1};
                end
                pend_v_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_head_reg <= link_t'(POOL_NODES - 1);
            main_head_reg <= NIL_LINK;
            even_head_reg <= NIL_LINK;
            pend_v_reg    <= 1'b0;
            strobe_reg    <= 1'b0;
        end
        else
        begin
            free_head_reg <= free_head_next;
            main_head_reg <= main_head_next;
            even_head_reg <= even_head_next;
            pend_v_reg    <= pend_v_next;
            strobe_reg    <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        prev_reg     <= prev_next;
        nxt_reg      <= nxt_next;
        cnt_reg      <= cnt_next;
        pass_reg     <= pass_next;
        value_reg    <= value_next;
        pend_id_reg  <= pend_id_next;
        pend_val_reg <= pend_val_next;
        result_reg   <= result_next;
    end

    assign result = result_reg;
    assign strobe = strobe_reg;

endmodule

>>> rtl/clps_checker.sv
// Port-level checker for the cursor list block, bound to the top level.
`timescale 1ns / 1ps
`include "cursor_list_parity_split_defines.svh"

module clps_checker
    import clps_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input logic    busy,
    input logic    strobe,
    input result_t result
);

    `CLPS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
    `CLPS_ASSERT_IMPLY(a_mid_busy, strobe && !result.last, busy, "non-final word after busy fell")
    `CLPS_ASSERT_IMPLY(a_full_word, strobe && result.status, !result.element_valid && result.last, "bad full status word")
    `CLPS_ASSERT_IMPLY(a_plain_last, strobe && !result.element_valid, result.last, "status word not final")
    `CLPS_ASSERT_IMPLY(a_end_last, $fell(busy), strobe && result.last, "busy fell without final word")

endmodule

bind cursor_list_parity_split clps_checker u_chk (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .strobe (strobe),
    .result (result)
);
